// File: hw/rtl/safd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// safd_pkg: shared types and constants of the spi angle sensor frame decoder
// Record kinds, the known register table and the job descriptor that the
// front end hands to the back end through the job queue.
// ----------------------------------------------------------------------------
package safd_pkg;

    // fixed field widths
    localparam int ADDR_W    = 14;
    localparam int ID_W      = 4;
    localparam int KIND_W    = 4;
    localparam int SPAN_W    = 48;
    localparam int MAX_RECS  = 4;
    localparam int CNT_W     = 3;
    localparam int SLOT_W    = 2;

    // job queue depth
    localparam int QUEUE_DEPTH = 2;

    // stream packing
    localparam int S_TDATA_W = 152;
    localparam int M_TDATA_W = 128;

    // record kinds
    localparam logic [KIND_W-1:0] KIND_CMD_READ    = 4'd0;
    localparam logic [KIND_W-1:0] KIND_CMD_WRITE   = 4'd1;
    localparam logic [KIND_W-1:0] KIND_READ_FRAME  = 4'd2;
    localparam logic [KIND_W-1:0] KIND_WRITE_FRAME = 4'd3;
    localparam logic [KIND_W-1:0] KIND_REG_READ    = 4'd4;
    localparam logic [KIND_W-1:0] KIND_REG_WRITE   = 4'd5;
    localparam logic [KIND_W-1:0] KIND_MOSI_PARITY = 4'd6;
    localparam logic [KIND_W-1:0] KIND_MISO_PARITY = 4'd7;
    localparam logic [KIND_W-1:0] KIND_ERROR_FLAG  = 4'd8;

    // command word fields
    localparam int RW_BIT = 14;
    localparam logic [ID_W-1:0] UNKNOWN_ID = 4'd11;
    localparam int NUM_KNOWN = 11;

    localparam logic [ADDR_W-1:0] KNOWN_REGS [NUM_KNOWN] = '{
        14'h0000, 14'h0001, 14'h0003, 14'h0016, 14'h0017, 14'h0018,
        14'h0019, 14'h3FFC, 14'h3FFD, 14'h3FFE, 14'h3FFF
    };

    typedef logic [SPAN_W-1:0] span_t;

    // one decoded word: the records it causes and their shared fields
    typedef struct packed {
        logic [MAX_RECS-1:0][KIND_W-1:0] kinds;
        logic [CNT_W-1:0]                count;
        logic [ADDR_W-1:0]               addr;
        logic [ID_W-1:0]                 id;
        logic [ADDR_W-1:0]               data;
        span_t                           frame_begin;
        span_t                           trans_begin;
        span_t                           span_end;
    } job_t;

    // map an address to its index in the known register table
    function automatic logic [ID_W-1:0] reg_lookup(input logic [ADDR_W-1:0] addr);
        logic [ID_W-1:0] id;
        id = UNKNOWN_ID;
        for (int i = NUM_KNOWN - 1; i >= 0; i--) begin
            if (KNOWN_REGS[i] == addr) begin
                id = ID_W'(i);
            end
        end
        return id;
    endfunction

endpackage

// File: hw/rtl/safd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// safd_front: event intake and word classification
// Pairs bytes into words, tracks the transaction phase and turns every
// completed word into a job descriptor listing the records it causes.
// ----------------------------------------------------------------------------
module safd_front #(
    parameter int TIMESTAMP_BITS = 48
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic [safd_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tuser,
    input  logic                           s_tready,
    output logic                           push_valid,
    output safd_pkg::job_t                 push_job
);

    localparam int TS_W = (TIMESTAMP_BITS < safd_pkg::SPAN_W) ?
                          TIMESTAMP_BITS : safd_pkg::SPAN_W;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_READ  = 2'd1;
    localparam logic [1:0] PH_WRITE = 2'd2;
    localparam logic [1:0] PH_SPARE = 2'd3;

    logic [1:0]      phase_reg, phase_next;
    logic            pending_reg, pending_next;
    logic [7:0]      mosi_hi_reg, mosi_hi_next;
    logic [7:0]      miso_hi_reg, miso_hi_next;
    logic [TS_W-1:0] frame_start_reg, frame_start_next;
    logic [TS_W-1:0] trans_begin_reg, trans_begin_next;
    logic [safd_pkg::ADDR_W-1:0] held_reg, held_next;

    logic                        in_fire;
    logic                        mosi_seen, miso_seen;
    logic [15:0]                 mosi_v, miso_v;
    logic [7:0]                  cs_old, cs_new;
    logic [TS_W-1:0]             ts_start, ts_end;
    logic                        wide;
    logic                        word_done;
    logic [15:0]                 mosi_w, miso_w;
    logic [TS_W-1:0]             word_start;
    logic                        par_mosi, par_miso;
    logic [safd_pkg::ADDR_W-1:0] rec_addr;
    logic [3:0]                  cand_en;
    logic [3:0][safd_pkg::KIND_W-1:0] cand_kind;
    logic [safd_pkg::CNT_W-1:0]  n;

    // field extraction
    assign in_fire   = s_tvalid & s_tready;
    assign mosi_seen = s_tdata[0];
    assign miso_seen = s_tdata[1];
    assign mosi_v    = s_tdata[17:2];
    assign miso_v    = s_tdata[33:18];
    assign cs_old    = s_tdata[41:34];
    assign cs_new    = s_tdata[49:42];
    assign ts_start  = s_tdata[50 +: TS_W];
    assign ts_end    = s_tdata[98 +: TS_W];

    // word assembly
    assign wide       = (|mosi_v[15:8]) | (|miso_v[15:8]);
    assign word_done  = wide | pending_reg;
    assign mosi_w     = wide ? mosi_v : {mosi_hi_reg, mosi_v[7:0]};
    assign miso_w     = wide ? miso_v : {miso_hi_reg, miso_v[7:0]};
    assign word_start = wide ? ts_start : frame_start_reg;
    assign par_mosi   = mosi_seen & (^mosi_w);
    assign par_miso   = miso_seen & (^miso_w);
    assign rec_addr   = (phase_reg == PH_IDLE) ? mosi_w[safd_pkg::ADDR_W-1:0] : held_reg;

    // candidate records in output order for the current phase
    always_comb begin
        cand_en   = '0;
        cand_kind = '0;
        case (phase_reg)
            PH_IDLE: begin
                cand_en      = {2'b00, 1'b1, par_mosi};
                cand_kind[0] = safd_pkg::KIND_MOSI_PARITY;
                cand_kind[1] = mosi_w[safd_pkg::RW_BIT] ? safd_pkg::KIND_CMD_READ
                                                        : safd_pkg::KIND_CMD_WRITE;
            end
            PH_READ: begin
                cand_en      = {2'b11, miso_w[safd_pkg::RW_BIT], par_miso};
                cand_kind[0] = safd_pkg::KIND_MISO_PARITY;
                cand_kind[1] = safd_pkg::KIND_ERROR_FLAG;
                cand_kind[2] = safd_pkg::KIND_READ_FRAME;
                cand_kind[3] = safd_pkg::KIND_REG_READ;
            end
            PH_WRITE: begin
                cand_en      = {2'b11, par_miso, par_mosi};
                cand_kind[0] = safd_pkg::KIND_MOSI_PARITY;
                cand_kind[1] = safd_pkg::KIND_MISO_PARITY;
                cand_kind[2] = safd_pkg::KIND_WRITE_FRAME;
                cand_kind[3] = safd_pkg::KIND_REG_WRITE;
            end
            PH_SPARE: begin
                cand_en      = {3'b000, par_miso};
                cand_kind[0] = safd_pkg::KIND_MISO_PARITY;
            end
            default: begin
                cand_en = '0;
            end
        endcase
    end

    // compact the enabled candidates into the job
    always_comb begin
        n              = '0;
        push_job       = '0;
        for (int i = 0; i < safd_pkg::MAX_RECS; i++) begin
            if (cand_en[i]) begin
                push_job.kinds[n[safd_pkg::SLOT_W-1:0]] = cand_kind[i];
                n = n + 3'd1;
            end
        end
        push_job.count       = n;
        push_job.addr        = rec_addr;
        push_job.id          = safd_pkg::reg_lookup(rec_addr);
        push_job.data        = (phase_reg == PH_READ) ? miso_w[safd_pkg::ADDR_W-1:0]
                                                      : mosi_w[safd_pkg::ADDR_W-1:0];
        push_job.frame_begin = safd_pkg::SPAN_W'(word_start);
        push_job.trans_begin = safd_pkg::SPAN_W'(trans_begin_reg);
        push_job.span_end    = safd_pkg::SPAN_W'(ts_end);
    end

    assign push_valid = in_fire & ~s_tuser & word_done & (n != '0);

    // decoder state update
    always_comb begin
        phase_next       = phase_reg;
        pending_next     = pending_reg;
        mosi_hi_next     = mosi_hi_reg;
        miso_hi_next     = miso_hi_reg;
        frame_start_next = frame_start_reg;
        trans_begin_next = trans_begin_reg;
        held_next        = held_reg;
        if (in_fire) begin
            if (s_tuser) begin
                if (cs_old == 8'd0 && cs_new == 8'd1) begin
                    phase_next   = PH_IDLE;
                    pending_next = 1'b0;
                end
            end else if (!word_done) begin
                mosi_hi_next     = mosi_v[7:0];
                miso_hi_next     = miso_v[7:0];
                frame_start_next = ts_start;
                pending_next     = 1'b1;
            end else begin
                if (!wide) begin
                    pending_next = 1'b0;
                end
                if (phase_reg == PH_IDLE) begin
                    trans_begin_next = word_start;
                    held_next        = mosi_w[safd_pkg::ADDR_W-1:0];
                    phase_next       = mosi_w[safd_pkg::RW_BIT] ? PH_READ : PH_WRITE;
                end else begin
                    phase_next = PH_IDLE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            pending_reg     <= 1'b0;
            mosi_hi_reg     <= '0;
            miso_hi_reg     <= '0;
            frame_start_reg <= '0;
            trans_begin_reg <= '0;
            held_reg        <= '0;
        end else begin
            phase_reg       <= phase_next;
            pending_reg     <= pending_next;
            mosi_hi_reg     <= mosi_hi_next;
            miso_hi_reg     <= miso_hi_next;
            frame_start_reg <= frame_start_next;
            trans_begin_reg <= trans_begin_next;
            held_reg        <= held_next;
        end
    end

endmodule

// File: hw/rtl/safd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// safd_queue: job queue between front end and back end
// A small register fifo of job descriptors so that intake and record
// output stall independently.
// ----------------------------------------------------------------------------
module safd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    input  safd_pkg::job_t push_job,
    output logic           push_ready,
    output logic           pop_valid,
    output safd_pkg::job_t pop_job,
    input  logic           pop
);

    localparam int DEPTH = safd_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    safd_pkg::job_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop & pop_valid;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: hw/rtl/safd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// safd_back: record sequencer
// Walks the record list of the job at the head of the queue and drives one
// record per cycle, while m_tready allows, into the registered result channel.
// ----------------------------------------------------------------------------
module safd_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           job_valid,
    input  safd_pkg::job_t                 job,
    output logic                           job_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [safd_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [safd_pkg::KIND_W-1:0]    m_tuser,
    output logic                           m_tlast
);

    logic [safd_pkg::SLOT_W-1:0]    slot_reg, slot_next;
    logic                           valid_reg, valid_next;
    logic [safd_pkg::M_TDATA_W-1:0] tdata_reg, tdata_next;
    logic [safd_pkg::KIND_W-1:0]    tuser_reg, tuser_next;
    logic                           tlast_reg, tlast_next;

    logic                           out_load;
    logic                           is_last;
    logic [safd_pkg::KIND_W-1:0]    kind;
    logic                           is_data, is_trans;
    logic [safd_pkg::ADDR_W-1:0]    rec_data;
    safd_pkg::span_t                rec_start;

    // current record of the head job
    assign out_load  = ~valid_reg | m_tready;
    assign kind      = job.kinds[slot_reg];
    assign is_last   = ({1'b0, slot_reg} + 3'd1) == job.count;
    assign is_trans  = (kind == safd_pkg::KIND_REG_READ) ||
                       (kind == safd_pkg::KIND_REG_WRITE);
    assign is_data   = is_trans || (kind == safd_pkg::KIND_READ_FRAME) ||
                       (kind == safd_pkg::KIND_WRITE_FRAME);
    assign rec_data  = is_data ? job.data : '0;
    assign rec_start = is_trans ? job.trans_begin : job.frame_begin;
    assign job_pop   = out_load & job_valid & is_last;

    // output register load
    always_comb begin
        slot_next  = slot_reg;
        valid_next = valid_reg;
        tdata_next = tdata_reg;
        tuser_next = tuser_reg;
        tlast_next = tlast_reg;
        if (out_load) begin
            valid_next = job_valid;
            if (job_valid) begin
                tdata_next = {job.span_end, rec_start, rec_data, job.id, job.addr};
                tuser_next = kind;
                tlast_next = is_last;
                slot_next  = is_last ? '0 : slot_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            slot_reg  <= slot_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tdata_reg <= tdata_next;
        tuser_reg <= tuser_next;
        tlast_reg <= tlast_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;
    assign m_tlast  = tlast_reg;

endmodule

// File: hw/rtl/spi_angle_sensor_frame_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_angle_sensor_frame_decoder_unit: spi register frame decoder
// Decodes sniffed spi events of a 14-bit register protocol with even parity
// into command, data frame, transaction and warning records.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one sniffer event per request: tuser high for a
//   chip-select change, low for a data transfer. Bytes are paired high byte
//   first; a value above 255 on either line is a whole word.
//   Each completed word yields one to four records on the m_ channel, one
//   per cycle while m_tready is high; tuser holds the record kind and tlast
//   marks the final record of an event. Events that finish no word yield
//   nothing. An accepted word passes through the job queue and then the
//   output register before its first record appears. An event is taken
//   every cycle while the two-entry job queue has room; records drain one
//   per cycle while the receiver is ready, bounded by the record sequencer.
//   When the receiver stalls, the output register holds its record, the
//   queue fills and s_tready drops once both entries are taken.
//   Reset (aresetn low, synchronous) returns the decoder to idle, clears
//   byte pairing and sample marks, and empties the queue and output.
// ----------------------------------------------------------------------------
module spi_angle_sensor_frame_decoder_unit #(
    parameter int TIMESTAMP_BITS = 48
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // mosi present, miso present, mosi value, miso value, old select,
    // new select, first sample, last sample (zero padded to 152 bits)
    input  logic [safd_pkg::S_TDATA_W-1:0] s_tdata,
    // mode
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // reg_address, reg_id, data_value, span_start, span_end
    output logic [safd_pkg::M_TDATA_W-1:0] m_tdata,
    // kind
    output logic [safd_pkg::KIND_W-1:0]    m_tuser,
    output logic                           m_tlast
);

    logic           push_valid, push_ready;
    safd_pkg::job_t push_job;
    logic           pop_valid, pop;
    safd_pkg::job_t pop_job;

    assign s_tready = push_ready;

    // intake and classification
    safd_front #(
        .TIMESTAMP_BITS(TIMESTAMP_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tready  (push_ready),
        .push_valid(push_valid),
        .push_job  (push_job)
    );

    // job queue
    safd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_job  (push_job),
        .push_ready(push_ready),
        .pop_valid (pop_valid),
        .pop_job   (pop_job),
        .pop       (pop)
    );

    // record output
    safd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .job_valid(pop_valid),
        .job      (pop_job),
        .job_pop  (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: sim/tb_spi_angle_sensor_frame_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spi_angle_sensor_frame_decoder_unit: self-checking bench for the decoder
// Drives sniffer events (transfers and chip-select changes) into the s_
// stream and checks every m_ record against a cycle-free decoder model,
// in order and field by field. It starts with hand-picked corner cases,
// then runs random register transactions mixed with noise under changing
// backpressure, including a long output stall and a full drain pause.
// ----------------------------------------------------------------------------
module tb_spi_angle_sensor_frame_decoder_unit;

    // event kinds on s_tuser
    localparam logic MODE_XFER   = 1'b0;
    localparam logic MODE_SELECT = 1'b1;
    localparam logic [7:0] CS_LOW     = 8'd0;
    localparam logic [7:0] CS_HIGH    = 8'd1;
    localparam logic [7:0] CS_UNKNOWN = 8'hFF;
    localparam safd_pkg::span_t SPAN_MAX = '1;

    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD   = 200;
    localparam int DRAIN_WAIT  = 20;
    localparam int PHASE_ITEMS = 60;

    typedef enum logic [1:0] {PH_IDLE, PH_READ_DATA, PH_WRITE_DATA} phase_t;

    // one sniffer event
    typedef struct packed {
        logic            mode;
        logic            mosi_seen;
        logic            miso_seen;
        logic [15:0]     mosi;
        logic [15:0]     miso;
        logic [7:0]      cs_old;
        logic [7:0]      cs_new;
        safd_pkg::span_t first_smp;
        safd_pkg::span_t last_smp;
    } sniff_evt_t;

    // one decoded record
    typedef struct packed {
        logic [safd_pkg::KIND_W-1:0] kind;
        logic [safd_pkg::ADDR_W-1:0] addr;
        logic [safd_pkg::ID_W-1:0]   id;
        logic [safd_pkg::ADDR_W-1:0] data;
        safd_pkg::span_t             span_start;
        safd_pkg::span_t             span_end;
        logic                        last;
    } record_t;

    // decoder model and record store
    class frame_scoreboard;
        phase_t                      phase;
        bit                          byte_pending;
        logic [7:0]                  mosi_hi;
        logic [7:0]                  miso_hi;
        safd_pkg::span_t             frame_start;
        safd_pkg::span_t             txn_begin;
        logic [safd_pkg::ADDR_W-1:0] held_reg;
        record_t                     staged[$];
        record_t                     expected_q[$];
        int                          mismatches;

        function new();
            phase        = PH_IDLE;
            byte_pending = 1'b0;
            mosi_hi      = '0;
            miso_hi      = '0;
            frame_start  = '0;
            txn_begin    = '0;
            held_reg     = '0;
            mismatches   = 0;
        endfunction

        function logic [safd_pkg::ID_W-1:0] lookup_id(logic [safd_pkg::ADDR_W-1:0] a);
            for (int i = 0; i < safd_pkg::NUM_KNOWN; i++) begin
                if (safd_pkg::KNOWN_REGS[i] == a) return safd_pkg::ID_W'(i);
            end
            return safd_pkg::UNKNOWN_ID;
        endfunction

        function void stage(logic [safd_pkg::KIND_W-1:0] kind,
                            logic [safd_pkg::ADDR_W-1:0] a,
                            logic [safd_pkg::ADDR_W-1:0] d,
                            safd_pkg::span_t ss, safd_pkg::span_t es);
            record_t r;
            r.kind       = kind;
            r.addr       = a;
            r.id         = lookup_id(a);
            r.data       = d;
            r.span_start = ss;
            r.span_end   = es;
            r.last       = 1'b0;
            staged.push_back(r);
        endfunction

        // advance the model by one accepted request
        function void note_request(sniff_evt_t e);
            logic [15:0]                 mw;
            logic [15:0]                 sw;
            safd_pkg::span_t             fss;
            safd_pkg::span_t             es;
            logic [safd_pkg::ADDR_W-1:0] a;
            record_t                     r;
            staged.delete();
            es = e.last_smp;
            if (e.mode == MODE_SELECT) begin
                if (e.cs_old == CS_LOW && e.cs_new == CS_HIGH) begin
                    phase        = PH_IDLE;
                    byte_pending = 1'b0;
                end
                return;
            end
            // assemble a word: whole word or second byte of a pair
            if (e.mosi > 16'h00FF || e.miso > 16'h00FF) begin
                mw  = e.mosi;
                sw  = e.miso;
                fss = e.first_smp;
            end else if (!byte_pending) begin
                mosi_hi      = e.mosi[7:0];
                miso_hi      = e.miso[7:0];
                frame_start  = e.first_smp;
                byte_pending = 1'b1;
                return;
            end else begin
                mw           = {mosi_hi, e.mosi[7:0]};
                sw           = {miso_hi, e.miso[7:0]};
                byte_pending = 1'b0;
                fss          = frame_start;
            end
            if (phase == PH_IDLE) begin
                // command word
                a = mw[safd_pkg::ADDR_W-1:0];
                if (e.mosi_seen && ^mw) stage(safd_pkg::KIND_MOSI_PARITY, a, '0, fss, es);
                txn_begin = fss;
                held_reg  = a;
                if (mw[safd_pkg::RW_BIT]) begin
                    phase = PH_READ_DATA;
                    stage(safd_pkg::KIND_CMD_READ, a, '0, fss, es);
                end else begin
                    phase = PH_WRITE_DATA;
                    stage(safd_pkg::KIND_CMD_WRITE, a, '0, fss, es);
                end
            end else begin
                // data word closes the transaction
                a = held_reg;
                if (phase == PH_WRITE_DATA && e.mosi_seen && ^mw)
                    stage(safd_pkg::KIND_MOSI_PARITY, a, '0, fss, es);
                if (e.miso_seen && ^sw) stage(safd_pkg::KIND_MISO_PARITY, a, '0, fss, es);
                if (phase == PH_READ_DATA) begin
                    if (sw[safd_pkg::RW_BIT]) stage(safd_pkg::KIND_ERROR_FLAG, a, '0, fss, es);
                    stage(safd_pkg::KIND_READ_FRAME, a, sw[safd_pkg::ADDR_W-1:0], fss, es);
                    stage(safd_pkg::KIND_REG_READ, a, sw[safd_pkg::ADDR_W-1:0], txn_begin, es);
                end else begin
                    stage(safd_pkg::KIND_WRITE_FRAME, a, mw[safd_pkg::ADDR_W-1:0], fss, es);
                    stage(safd_pkg::KIND_REG_WRITE, a, mw[safd_pkg::ADDR_W-1:0], txn_begin, es);
                end
                phase = PH_IDLE;
            end
            foreach (staged[i]) begin
                r      = staged[i];
                r.last = (i == staged.size() - 1);
                expected_q.push_back(r);
            end
        endfunction

        // compare one accepted record with the oldest expected one
        function void check_record(record_t got);
            record_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected record kind %0d addr %h data %h",
                             got.kind, got.addr, got.data);
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind || got.addr !== want.addr || got.id !== want.id ||
                got.data !== want.data || got.span_start !== want.span_start ||
                got.span_end !== want.span_end || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: exp kind %0d addr %h id %0d data %h span %h..%h last %b",
                             want.kind, want.addr, want.id, want.data,
                             want.span_start, want.span_end, want.last);
                    $display("       got kind %0d addr %h id %0d data %h span %h..%h last %b",
                             got.kind, got.addr, got.id, got.data,
                             got.span_start, got.span_end, got.last);
                end
            end
        endfunction
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [safd_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                           s_tuser = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [safd_pkg::M_TDATA_W-1:0] m_tdata;
    logic [safd_pkg::KIND_W-1:0]    m_tuser;
    logic                           m_tlast;

    frame_scoreboard sb = new();
    int              tx_idle_pct = 0;
    int              rx_idle_pct = 0;
    bit              hold_req = 1'b0;
    int              hold_left = 0;
    int              stall_cycles = 0;
    int              sent = 0;
    safd_pkg::span_t sample_now = '0;

    spi_angle_sensor_frame_decoder_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver backpressure, with an optional long hold-off
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        record_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind       = m_tuser;
            got.addr       = m_tdata[13:0];
            got.id         = m_tdata[17:14];
            got.data       = m_tdata[31:18];
            got.span_start = m_tdata[79:32];
            got.span_end   = m_tdata[127:80];
            got.last       = m_tlast;
            sb.check_record(got);
        end
    end

    // watchdog on cycles without any request moving
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
            else stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("spi_angle_sensor_frame_decoder_unit: mismatch");
                $finish;
            end
        end
    end

    function automatic safd_pkg::span_t rand_span();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // even parity lives in bit 15
    function automatic logic [15:0] even_word(logic [14:0] low);
        return {^low, low};
    endfunction

    // offer one event and wait for its handshake
    task automatic send(input sniff_evt_t e);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= e.mode;
        s_tdata  <= {6'b0, e.last_smp, e.first_smp, e.cs_new, e.cs_old,
                     e.miso, e.mosi, e.miso_seen, e.mosi_seen};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(e);
        sent++;
    endtask

    task automatic xfer_at(input logic hm, input logic hs, input logic [15:0] mv,
                           input logic [15:0] sv, input safd_pkg::span_t ss,
                           input safd_pkg::span_t es);
        sniff_evt_t e;
        e = '{mode: MODE_XFER, mosi_seen: hm, miso_seen: hs, mosi: mv, miso: sv,
              cs_old: 8'($urandom), cs_new: 8'($urandom), first_smp: ss, last_smp: es};
        send(e);
    endtask

    task automatic xfer(input logic hm, input logic hs, input logic [15:0] mv,
                        input logic [15:0] sv);
        safd_pkg::span_t ss;
        ss         = sample_now;
        sample_now = ss + $urandom_range(1, 40);
        xfer_at(hm, hs, mv, sv, ss, sample_now);
        sample_now = sample_now + $urandom_range(0, 10);
    endtask

    task automatic select_change(input logic [7:0] cs_from, input logic [7:0] cs_to);
        sniff_evt_t e;
        e = '{mode: MODE_SELECT, mosi_seen: 1'($urandom_range(1)),
              miso_seen: 1'($urandom_range(1)),
              mosi: 16'($urandom), miso: 16'($urandom), cs_old: cs_from, cs_new: cs_to,
              first_smp: sample_now, last_smp: sample_now + 1};
        send(e);
        sample_now = sample_now + 2;
    endtask

    // one word, either whole or as a high/low byte pair
    task automatic put_word(input logic hm, input logic hs, input logic [15:0] mw,
                            input logic [15:0] sw, input bit split);
        if (split) begin
            xfer(hm, hs, {8'h00, mw[15:8]}, {8'h00, sw[15:8]});
            xfer(hm, hs, {8'h00, mw[7:0]}, {8'h00, sw[7:0]});
        end else begin
            xfer(hm, hs, mw, sw);
        end
    endtask

    // well-formed register access, sometimes with errors or cut short
    task automatic transaction();
        logic [safd_pkg::ADDR_W-1:0] addr;
        logic [15:0]                 cmd;
        logic [15:0]                 dm;
        logic [15:0]                 ds;
        bit                          split;
        select_change(CS_HIGH, CS_LOW);
        addr  = $urandom_range(1) ?
                safd_pkg::KNOWN_REGS[4'($urandom_range(safd_pkg::NUM_KNOWN - 1))] :
                14'($urandom);
        split = 1'($urandom_range(1));
        cmd   = even_word({1'($urandom_range(1)), addr});
        if ($urandom_range(9) == 0) cmd[15] = ~cmd[15];
        put_word($urandom_range(5) != 0, 1'($urandom_range(1)), cmd, 16'($urandom), split);
        if ($urandom_range(7) != 0) begin
            dm = even_word(15'($urandom));
            ds = even_word({1'b0, 14'($urandom)});
            if ($urandom_range(7) == 0) ds = even_word({1'b1, 14'($urandom)});
            if ($urandom_range(9) == 0) dm[15] = ~dm[15];
            if ($urandom_range(9) == 0) ds[15] = ~ds[15];
            put_word($urandom_range(5) != 0, $urandom_range(5) != 0, dm, ds, split);
        end
        if ($urandom_range(9) != 0) select_change(CS_LOW, CS_HIGH);
    endtask

    // random event of any shape
    task automatic noise_event();
        sniff_evt_t e;
        e.mode      = 1'($urandom_range(1));
        e.mosi_seen = 1'($urandom_range(1));
        e.miso_seen = 1'($urandom_range(1));
        e.mosi      = $urandom_range(1) ? 16'($urandom_range(255)) : 16'($urandom);
        e.miso      = $urandom_range(1) ? 16'($urandom_range(255)) : 16'($urandom);
        e.cs_old    = $urandom_range(3) == 0 ? CS_LOW : 8'($urandom);
        e.cs_new    = $urandom_range(3) == 0 ? CS_HIGH : 8'($urandom);
        e.first_smp = rand_span();
        e.last_smp  = rand_span();
        send(e);
    endtask

    task automatic random_phase(input int tx_pct, input int rx_pct);
        int stop_at;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        stop_at     = sent + PHASE_ITEMS;
        while (sent < stop_at) begin
            if ($urandom_range(4) == 0) noise_event();
            else transaction();
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // an ignored select change, a real rise, then a fall that must be ignored
        select_change(CS_UNKNOWN, CS_HIGH);
        select_change(CS_LOW, CS_HIGH);
        select_change(CS_HIGH, CS_LOW);
        // write to the top address, data with both parity warnings, span extremes
        xfer_at(1'b1, 1'b1, 16'h3FFF, 16'h0000, '0, 48'd5);
        xfer_at(1'b1, 1'b1, 16'h7FFF, 16'h0001, 48'd6, SPAN_MAX);
        // read command as a byte pair with bad parity, data with error flag
        put_word(1'b1, 1'b1, 16'h4000, 16'h0000, 1'b1);
        xfer(1'b1, 1'b1, 16'h0100, 16'hC000);
        // read command with mosi absent, then its data word with miso absent
        xfer(1'b0, 1'b1, 16'h4001, 16'h0000);
        xfer(1'b1, 1'b0, 16'h0000, 16'h0107);
        // select rise in the middle of a byte pair and of a transaction
        xfer(1'b1, 1'b1, 16'h0040, 16'h0012);
        select_change(CS_LOW, CS_HIGH);
        xfer(1'b1, 1'b1, 16'h8016, 16'h0000);
        select_change(CS_LOW, CS_HIGH);
        // whole word while a byte pair is open
        xfer(1'b1, 1'b1, 16'h0040, 16'h0000);
        xfer(1'b1, 1'b1, 16'hC003, 16'h0000);
        xfer(1'b1, 1'b1, 16'h0000, 16'h00FF);
        // sample numbers at the top of the range
        xfer_at(1'b1, 1'b1, 16'h8117, 16'h0000, SPAN_MAX, '0);
        xfer_at(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, SPAN_MAX, SPAN_MAX);
        select_change(CS_LOW, CS_LOW);
        select_change(CS_HIGH, CS_HIGH);
        select_change(CS_LOW, CS_UNKNOWN);
        select_change(8'hFE, CS_HIGH);

        // random traffic under three backpressure regimes
        random_phase(16, 82);
        random_phase(82, 16);
        wait_drained();
        hold_req = 1'b1;
        random_phase(0, 0);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("spi_angle_sensor_frame_decoder_unit: match");
        end else begin
            $display("spi_angle_sensor_frame_decoder_unit: mismatch");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/safd_pkg.sv
hw/rtl/safd_front.sv
hw/rtl/safd_queue.sv
hw/rtl/safd_back.sv
hw/rtl/spi_angle_sensor_frame_decoder_unit.sv
sim/tb_spi_angle_sensor_frame_decoder_unit.sv
